/* rtl/ligp_pkg.sv */
package ligp_pkg;

    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLS    = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Grid dimensions, cell coordinates and path lengths.
    localparam int SIZE_W    = 6;
    localparam int LEN_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

    // Neighbour order: up, right, down, left; the fifth code means all are done.
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_STEP,
        ST_NEIGH,
        ST_POP,
        ST_DONE
    } walk_state_t;

endpackage

/* rtl/longest_increasing_grid_path.sv */
// Cells load one item per cycle while busy is low and cfg_we is low; only the last cell of a grid
// gives a result. That cell starts a search of the grid: it clears the memo store, scans each cell
// in a read state and a check state, and for each cell the walk reads and judges every in-grid
// neighbour, then closes the cell and returns to its parent, all through the shared read port.
// Then done is high with path_length for one cycle; the receiver cannot stall it. Reset clears
// the sequencer, the load count, the grid size (1 by 1) and the held result (1), not memories.
module longest_increasing_grid_path #(
    parameter int MAX_ROWS    = ligp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = ligp_pkg::DEF_MAX_COLS,
    parameter int VALUE_WIDTH = ligp_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [VALUE_WIDTH-1:0]   cell_value,
    output logic                            done,
    output logic [ligp_pkg::LEN_W-1:0]      path_length,
    input  logic                            cfg_we,
    input  logic [ligp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ligp_pkg::SIZE_W-1:0]     cfg_data
);
    import ligp_pkg::*;

    // Storage geometry. A count needs one bit more than an index so it can hold the
    // full cell count.
    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W   = CELL_AW + 1;

    // The memories. Cell values are stored as order-preserving keys: flipping the sign
    // bit lets a plain unsigned compare order two's complement values correctly.
    logic [VALUE_WIDTH-1:0] cell_mem [CELLS];
    logic [LEN_W-1:0]       memo_mem [CELLS];

    // The walk stack holds every level below the one being worked on, which is kept
    // in the top_* registers. All six arrays share one address.
    logic [CELL_AW-1:0]     stk_cell_mem [CELLS];
    logic [SIZE_W-1:0]      stk_row_mem  [CELLS];
    logic [SIZE_W-1:0]      stk_col_mem  [CELLS];
    logic [DIR_W-1:0]       stk_dir_mem  [CELLS];
    logic [LEN_W-1:0]       stk_best_mem [CELLS];
    logic [VALUE_WIDTH-1:0] stk_key_mem  [CELLS];

    walk_state_t state_reg, state_next;

    logic [SIZE_W-1:0]      rows_reg, rows_next;
    logic [SIZE_W-1:0]      cols_reg, cols_next;
    logic [CNT_W-1:0]       load_cnt_reg, load_cnt_next;
    logic [LEN_W-1:0]       best_len_reg, best_len_next;

    // Scan position: index, row and column of the start cell under examination. The
    // clearing pass uses the same index counter.
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [SIZE_W-1:0]      srow_reg, srow_next;
    logic [SIZE_W-1:0]      scol_reg, scol_next;

    // Current top of the walk.
    logic [CELL_AW-1:0]     top_cell_reg, top_cell_next;
    logic [SIZE_W-1:0]      top_row_reg, top_row_next;
    logic [SIZE_W-1:0]      top_col_reg, top_col_next;
    logic [DIR_W-1:0]       top_dir_reg, top_dir_next;
    logic [LEN_W-1:0]       top_best_reg, top_best_next;
    logic [VALUE_WIDTH-1:0] top_key_reg, top_key_next;

    // Neighbour that has been read and waits for its verdict.
    logic [CELL_AW-1:0]     nb_cell_reg, nb_cell_next;
    logic [SIZE_W-1:0]      nb_row_reg, nb_row_next;
    logic [SIZE_W-1:0]      nb_col_reg, nb_col_next;

    logic [CNT_W-1:0]       depth_reg, depth_next;
    logic [LEN_W-1:0]       pop_len_reg, pop_len_next;

    // Memory ports.
    logic                   cell_we;
    logic [CELL_AW-1:0]     cell_waddr;
    logic [VALUE_WIDTH-1:0] cell_wdata;
    logic                   memo_we;
    logic [CELL_AW-1:0]     memo_waddr;
    logic [LEN_W-1:0]       memo_wdata;
    logic [CELL_AW-1:0]     rd_addr;
    logic [VALUE_WIDTH-1:0] cell_rd;
    logic [LEN_W-1:0]       memo_rd;
    logic                   stk_we;
    logic [CELL_AW-1:0]     stk_addr;
    logic [CELL_AW-1:0]     stk_rd_cell;
    logic [SIZE_W-1:0]      stk_rd_row;
    logic [SIZE_W-1:0]      stk_rd_col;
    logic [DIR_W-1:0]       stk_rd_dir;
    logic [LEN_W-1:0]       stk_rd_best;
    logic [VALUE_WIDTH-1:0] stk_rd_key;

    logic [2*SIZE_W-1:0]    total_prod;
    logic [CNT_W-1:0]       total;
    logic [CNT_W-1:0]       last_idx;
    logic [SIZE_W-1:0]      last_row;
    logic [SIZE_W-1:0]      last_col;
    logic [CELL_AW-1:0]     cols_step;
    logic [LEN_W-1:0]       fin_len;
    logic [SIZE_W-1:0]      cfg_clamp_rows;
    logic [SIZE_W-1:0]      cfg_clamp_cols;

    assign total_prod = rows_reg * cols_reg;
    assign total      = CNT_W'(total_prod);
    assign last_idx   = total - CNT_W'(1);
    assign last_row   = rows_reg - SIZE_W'(1);
    assign last_col   = cols_reg - SIZE_W'(1);
    assign cols_step  = CELL_AW'(cols_reg);
    assign fin_len    = top_best_reg + LEN_W'(1);

    // A size of zero counts as one, and a size above the maximum as the maximum.
    always_comb
    begin
        if (cfg_data == '0)
            cfg_clamp_rows = SIZE_W'(1);
        else if (32'(cfg_data) > MAX_ROWS)
            cfg_clamp_rows = SIZE_W'(MAX_ROWS);
        else
            cfg_clamp_rows = cfg_data;

        if (cfg_data == '0)
            cfg_clamp_cols = SIZE_W'(1);
        else if (32'(cfg_data) > MAX_COLS)
            cfg_clamp_cols = SIZE_W'(MAX_COLS);
        else
            cfg_clamp_cols = cfg_data;
    end

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        cell_rd <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (memo_we)
            memo_mem[memo_waddr] <= memo_wdata;
        memo_rd <= memo_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_cell_mem[stk_addr] <= top_cell_reg;
            stk_row_mem[stk_addr]  <= top_row_reg;
            stk_col_mem[stk_addr]  <= top_col_reg;
            stk_dir_mem[stk_addr]  <= top_dir_reg;
            stk_best_mem[stk_addr] <= top_best_reg;
            stk_key_mem[stk_addr]  <= top_key_reg;
        end
        stk_rd_cell <= stk_cell_mem[stk_addr];
        stk_rd_row  <= stk_row_mem[stk_addr];
        stk_rd_col  <= stk_col_mem[stk_addr];
        stk_rd_dir  <= stk_dir_mem[stk_addr];
        stk_rd_best <= stk_best_mem[stk_addr];
        stk_rd_key  <= stk_key_mem[stk_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            rows_reg     <= SIZE_W'(1);
            cols_reg     <= SIZE_W'(1);
            load_cnt_reg <= '0;
            best_len_reg <= LEN_W'(1);
            idx_reg      <= '0;
            depth_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            load_cnt_reg <= load_cnt_next;
            best_len_reg <= best_len_next;
            idx_reg      <= idx_next;
            depth_reg    <= depth_next;
        end
    end

    // Walk payload registers.
    always_ff @(posedge clk)
    begin
        srow_reg     <= srow_next;
        scol_reg     <= scol_next;
        top_cell_reg <= top_cell_next;
        top_row_reg  <= top_row_next;
        top_col_reg  <= top_col_next;
        top_dir_reg  <= top_dir_next;
        top_best_reg <= top_best_next;
        top_key_reg  <= top_key_next;
        nb_cell_reg  <= nb_cell_next;
        nb_row_reg   <= nb_row_next;
        nb_col_reg   <= nb_col_next;
        pop_len_reg  <= pop_len_next;
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        load_cnt_next = load_cnt_reg;
        best_len_next = best_len_reg;
        idx_next      = idx_reg;
        srow_next     = srow_reg;
        scol_next     = scol_reg;
        top_cell_next = top_cell_reg;
        top_row_next  = top_row_reg;
        top_col_next  = top_col_reg;
        top_dir_next  = top_dir_reg;
        top_best_next = top_best_reg;
        top_key_next  = top_key_reg;
        nb_cell_next  = nb_cell_reg;
        nb_row_next   = nb_row_reg;
        nb_col_next   = nb_col_reg;
        depth_next    = depth_reg;
        pop_len_next  = pop_len_reg;

        cell_we    = 1'b0;
        cell_waddr = load_cnt_reg[CELL_AW-1:0];
        cell_wdata = cell_value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        memo_we    = 1'b0;
        memo_waddr = idx_reg[CELL_AW-1:0];
        memo_wdata = '0;
        rd_addr    = idx_reg[CELL_AW-1:0];
        stk_we     = 1'b0;
        stk_addr   = depth_reg[CELL_AW-1:0];

        // A write to the row or column register abandons a partly loaded grid.
        if (cfg_we)
        begin
            if (cfg_index == REG_GRID_ROWS)
            begin
                rows_next     = cfg_clamp_rows;
                load_cnt_next = '0;
            end
            else if (cfg_index == REG_GRID_COLS)
            begin
                cols_next     = cfg_clamp_cols;
                load_cnt_next = '0;
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (start && !cfg_we)
                begin
                    cell_we = 1'b1;
                    if (load_cnt_reg == last_idx)
                    begin
                        load_cnt_next = '0;
                        idx_next      = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end

            ST_CLEAR:
            begin
                memo_we = 1'b1;
                if (idx_reg == last_idx)
                begin
                    idx_next      = '0;
                    srow_next     = '0;
                    scol_next     = '0;
                    best_len_next = LEN_W'(1);
                    state_next    = ST_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_SCAN:
            begin
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (memo_rd != '0)
                begin
                    if (idx_reg == last_idx)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                    idx_next = idx_reg + CNT_W'(1);
                    if (scol_reg == last_col)
                    begin
                        scol_next = '0;
                        srow_next = srow_reg + SIZE_W'(1);
                    end
                    else
                    begin
                        scol_next = scol_reg + SIZE_W'(1);
                    end
                end
                else
                begin
                    top_cell_next = idx_reg[CELL_AW-1:0];
                    top_row_next  = srow_reg;
                    top_col_next  = scol_reg;
                    top_key_next  = cell_rd;
                    top_dir_next  = DIR_UP;
                    top_best_next = '0;
                    state_next    = ST_STEP;
                end
            end

            ST_STEP:
            begin
                if (top_dir_reg != DIR_END)
                begin
                    top_dir_next = top_dir_reg + DIR_W'(1);
                    nb_row_next  = top_row_reg;
                    nb_col_next  = top_col_reg;
                    nb_cell_next = top_cell_reg;
                    case (top_dir_reg)
                        DIR_UP:
                        begin
                            nb_row_next  = top_row_reg - SIZE_W'(1);
                            nb_cell_next = top_cell_reg - cols_step;
                            if (top_row_reg != '0)
                                state_next = ST_NEIGH;
                        end
                        DIR_RIGHT:
                        begin
                            nb_col_next  = top_col_reg + SIZE_W'(1);
                            nb_cell_next = top_cell_reg + CELL_AW'(1);
                            if (top_col_reg != last_col)
                                state_next = ST_NEIGH;
                        end
                        DIR_DOWN:
                        begin
                            nb_row_next  = top_row_reg + SIZE_W'(1);
                            nb_cell_next = top_cell_reg + cols_step;
                            if (top_row_reg != last_row)
                                state_next = ST_NEIGH;
                        end
                        DIR_LEFT:
                        begin
                            nb_col_next  = top_col_reg - SIZE_W'(1);
                            nb_cell_next = top_cell_reg - CELL_AW'(1);
                            if (top_col_reg != '0)
                                state_next = ST_NEIGH;
                        end
                        default:
                        begin
                            state_next = ST_STEP;
                        end
                    endcase
                    rd_addr = nb_cell_next;
                end
                else
                begin
                    // All four neighbours seen: this cell's length is final.
                    memo_we    = 1'b1;
                    memo_waddr = top_cell_reg;
                    memo_wdata = fin_len;
                    if (fin_len > best_len_reg)
                        best_len_next = fin_len;
                    if (depth_reg == '0)
                    begin
                        if (idx_reg == last_idx)
                            state_next = ST_DONE;
                        else
                            state_next = ST_SCAN;
                        idx_next = idx_reg + CNT_W'(1);
                        if (scol_reg == last_col)
                        begin
                            scol_next = '0;
                            srow_next = srow_reg + SIZE_W'(1);
                        end
                        else
                        begin
                            scol_next = scol_reg + SIZE_W'(1);
                        end
                    end
                    else
                    begin
                        stk_addr     = CELL_AW'(depth_reg - CNT_W'(1));
                        pop_len_next = fin_len;
                        state_next   = ST_POP;
                    end
                end
            end

            ST_NEIGH:
            begin
                state_next = ST_STEP;
                if (cell_rd > top_key_reg)
                begin
                    if (memo_rd != '0)
                    begin
                        if (memo_rd > top_best_reg)
                            top_best_next = memo_rd;
                    end
                    else
                    begin
                        // Unknown neighbour: descend into it.
                        stk_we        = 1'b1;
                        depth_next    = depth_reg + CNT_W'(1);
                        top_cell_next = nb_cell_reg;
                        top_row_next  = nb_row_reg;
                        top_col_next  = nb_col_reg;
                        top_key_next  = cell_rd;
                        top_dir_next  = DIR_UP;
                        top_best_next = '0;
                    end
                end
            end

            ST_POP:
            begin
                top_cell_next = stk_rd_cell;
                top_row_next  = stk_rd_row;
                top_col_next  = stk_rd_col;
                top_dir_next  = stk_rd_dir;
                top_key_next  = stk_rd_key;
                top_best_next = (pop_len_reg > stk_rd_best) ? pop_len_reg : stk_rd_best;
                depth_next    = depth_reg - CNT_W'(1);
                state_next    = ST_STEP;
            end

            ST_DONE:
            begin
                state_next = ST_LOAD;
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        busy        = (state_reg != ST_LOAD);
        done        = (state_reg == ST_DONE);
        path_length = best_len_reg;
    end

    // A result only ever follows a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding search");

    // A path always holds at least its start cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (path_length != '0))
        else $error("zero path length reported");

    // The walk never stacks more levels than the grid has cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (depth_reg < total))
        else $error("walk stack deeper than the grid");

    // A cell is only taken while the block is loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_we |-> (state_reg == ST_LOAD))
        else $error("cell written outside loading");

endmodule
